[hw/rtl/qed_pkg.sv]
// quadrature encoder decoder: shared types, codes and lookup functions
// no dependencies; used by qed_div, the top level and the testbench
package qed_pkg;

  localparam int QUO_W = 10;
  localparam logic [QUO_W-1:0] SPEED_NUM = 10'd1000;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_SLOW_UP = 3'd1;
  localparam logic [2:0] EV_SLOW_DN = 3'd2;
  localparam logic [2:0] EV_FAST_UP = 3'd3;
  localparam logic [2:0] EV_FAST_DN = 3'd4;

  localparam logic [1:0] CFG_ENC_TYPE   = 2'd0;
  localparam logic [1:0] CFG_FAST_LIMIT = 2'd1;
  localparam logic [1:0] CFG_MAX_POS    = 2'd2;

  localparam logic [2:0] ENC_TYPE_HI = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_EVAL,
    ST_DONE
  } qed_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_sts_t;

  // transition step from old and new pin state
  function automatic logic signed [1:0] step_dir(input logic [1:0] old_p,
                                                 input logic [1:0] new_p);
    logic signed [1:0] d;
    case ({old_p, new_p})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: d = -2'sd1;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: d = 2'sd1;
      default:                            d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] res_shift(input logic [2:0] typ);
    logic [1:0] s;
    case (typ)
      3'd0, 3'd1: s = 2'd2;
      3'd2, 3'd3: s = 2'd1;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic is_detent(input logic [2:0] typ, input logic [1:0] pins);
    logic [3:0] m;
    case (typ)
      3'd0:    m = 4'h8;
      3'd1:    m = 4'h1;
      3'd2:    m = 4'h9;
      3'd3:    m = 4'h6;
      default: m = 4'hF;
    endcase
    return m[pins];
  endfunction

endpackage

[hw/rtl/qed_if.sv]
// quadrature encoder decoder: sample and result channel interfaces
// depends on nothing; used by the top level
interface qed_in_if;
  logic        valid;
  logic        ready;
  logic        pin_a;
  logic        pin_b;
  logic [31:0] now_ms;

  modport source (output valid, pin_a, pin_b, now_ms, input ready);
  modport sink   (input valid, pin_a, pin_b, now_ms, output ready);
endinterface

interface qed_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic signed [15:0] position;

  modport source (output valid, event_res, position, input ready);
  modport sink   (input valid, event_res, position, output ready);
endinterface

[hw/rtl/qed_div.sv]
// quadrature encoder decoder: iterative restoring divider, 1000 / divisor
// one quotient bit per cycle; depends on qed_pkg
module qed_div (
  input  logic              clk,
  input  logic              rst_n,
  input  qed_pkg::div_ctl_t ctl,
  output qed_pkg::div_sts_t sts
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic [qed_pkg::QUO_W-1:0] rem_r, rem_nxt;
  logic [qed_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [31:0]               div_r, div_nxt;
  logic [qed_pkg::QUO_W:0]   trial;
  logic                      ge;

  always_comb begin
    trial = {rem_r, qed_pkg::SPEED_NUM[4'(qed_pkg::QUO_W - 1) - cnt_r]};
    ge    = (div_r != 32'd0) && ({21'd0, trial} >= div_r);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      rem_nxt  = '0;
      quo_nxt  = '0;
      div_nxt  = ctl.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? qed_pkg::QUO_W'(trial - div_r[qed_pkg::QUO_W:0])
                   : trial[qed_pkg::QUO_W-1:0];
      quo_nxt = {quo_r[qed_pkg::QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(qed_pkg::QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign sts.done = done_r;
  assign sts.quo  = quo_r;

endmodule

[hw/rtl/quadrature_encoder_accel_decoder.sv]
// quadrature encoder decoder with speed-scaled steps and turn events
// a sample with changed pins passes the divide, step, evaluate and done states; one with unchanged
// pins goes straight to evaluate and done; a new sample is taken only once the last result has
// been loaded into the output register; the 10-step divider forms the speed factor
// synchronous active-low reset clears config to defaults and all position state
// depends on qed_pkg, qed_if, qed_div
module quadrature_encoder_accel_decoder (
  input  logic        clk,
  input  logic        rst_n,
  qed_in_if.sink      in_ch,
  qed_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);

  qed_pkg::qed_state_t state_r, state_nxt;
  qed_pkg::div_ctl_t   div_ctl;
  qed_pkg::div_sts_t   div_sts;

  logic [2:0]  enc_type_r;
  logic [14:0] fast_limit_r;
  logic [14:0] max_pos_r;

  logic [1:0]  last_pins_r;
  logic [31:0] fine_r;
  logic [15:0] detent_r;
  logic [15:0] reported_r;
  logic [31:0] last_time_r;
  logic [31:0] prior_time_r;

  logic [1:0]  pins_r;
  logic [31:0] now_r;
  logic [2:0]  ev_r;

  logic        out_valid_r;
  logic [2:0]  out_ev_r;
  logic [15:0] out_pos_r;

  logic        in_acc;
  logic [1:0]  pins_in;
  logic        slot_free;
  logic        out_load;

  // step datapath
  logic [1:0]         shift;
  logic signed [1:0]  dir;
  logic [10:0]        speed;
  logic [31:0]        inc;
  logic [31:0]        fine_step;
  logic signed [31:0] fine_sh;
  logic               at_detent;

  // movement datapath
  logic signed [15:0] delta_s;
  logic [15:0]        mag;
  logic               moved;
  logic               up;
  logic               fast;
  logic signed [17:0] probe;
  logic signed [17:0] lim;
  logic               clear;
  logic [2:0]         ev_calc;

  assign pins_in   = {in_ch.pin_b, in_ch.pin_a};
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  qed_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .sts   (div_sts)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qed_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = (pins_in != last_pins_r) ? qed_pkg::ST_DIV : qed_pkg::ST_EVAL;
      end
      qed_pkg::ST_DIV: begin
        if (div_sts.done) state_nxt = qed_pkg::ST_STEP;
      end
      qed_pkg::ST_STEP: state_nxt = qed_pkg::ST_EVAL;
      qed_pkg::ST_EVAL: state_nxt = qed_pkg::ST_DONE;
      qed_pkg::ST_DONE: begin
        if (slot_free) state_nxt = qed_pkg::ST_IDLE;
      end
      default: state_nxt = qed_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready     = (state_r == qed_pkg::ST_IDLE);
    div_ctl.start   = (state_r == qed_pkg::ST_IDLE) && in_ch.valid && (pins_in != last_pins_r);
    div_ctl.divisor = 32'd1 + last_time_r - prior_time_r;
    out_load        = (state_r == qed_pkg::ST_DONE) && slot_free;
  end

  always_comb begin
    shift     = qed_pkg::res_shift(enc_type_r);
    dir       = qed_pkg::step_dir(last_pins_r, pins_r);
    speed     = 11'd1 + {1'b0, div_sts.quo};
    if (dir == 2'sd1) begin
      inc = {21'd0, speed};
    end else if (dir == -2'sd1) begin
      inc = 32'd0 - {21'd0, speed};
    end else begin
      inc = 32'd0;
    end
    fine_step = fine_r + (inc << shift);
    fine_sh   = $signed(fine_step) >>> shift;
    at_detent = qed_pkg::is_detent(enc_type_r, pins_r);
  end

  always_comb begin
    moved   = (detent_r != reported_r);
    delta_s = $signed(detent_r - reported_r);
    up      = !delta_s[15];
    mag     = up ? delta_s : 16'(16'd0 - delta_s);
    fast    = (mag >= {1'b0, fast_limit_r});
    probe   = $signed({{2{detent_r[15]}}, detent_r}) + $signed({delta_s[15], delta_s, 1'b0});
    lim     = $signed({3'd0, max_pos_r});
    clear   = moved && (up ? (probe > lim) : (probe < -lim));
    if (!moved) begin
      ev_calc = qed_pkg::EV_NONE;
    end else if (fast) begin
      ev_calc = up ? qed_pkg::EV_FAST_UP : qed_pkg::EV_FAST_DN;
    end else begin
      ev_calc = up ? qed_pkg::EV_SLOW_UP : qed_pkg::EV_SLOW_DN;
    end
  end

  // control, config and position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qed_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      enc_type_r   <= 3'd0;
      fast_limit_r <= 15'd5;
      max_pos_r    <= 15'd30000;
      last_pins_r  <= 2'd0;
      fine_r       <= 32'd0;
      detent_r     <= 16'd0;
      reported_r   <= 16'd0;
      last_time_r  <= 32'd0;
      prior_time_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          qed_pkg::CFG_ENC_TYPE: begin
            enc_type_r <= (cfg_wdata[2:0] > qed_pkg::ENC_TYPE_HI) ? qed_pkg::ENC_TYPE_HI
                                                                   : cfg_wdata[2:0];
          end
          qed_pkg::CFG_FAST_LIMIT: fast_limit_r <= cfg_wdata;
          qed_pkg::CFG_MAX_POS:    max_pos_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == qed_pkg::ST_STEP) begin
        fine_r      <= fine_step;
        last_pins_r <= pins_r;
        if (at_detent) begin
          prior_time_r <= last_time_r;
          last_time_r  <= now_r;
          detent_r     <= fine_sh[15:0];
        end
      end
      if (state_r == qed_pkg::ST_EVAL && moved) begin
        if (clear) begin
          fine_r     <= {30'd0, fine_r[1:0]};
          detent_r   <= 16'd0;
          reported_r <= 16'd0;
        end else begin
          reported_r <= detent_r;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pins_r <= pins_in;
      now_r  <= in_ch.now_ms;
    end
    if (state_r == qed_pkg::ST_EVAL) ev_r <= ev_calc;
    if (out_load) begin
      out_ev_r  <= ev_r;
      out_pos_r <= reported_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = out_ev_r;
  assign out_ch.position  = $signed(out_pos_r);

  a_same_pins_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pins_in == last_pins_r) |=> (state_r == qed_pkg::ST_EVAL))
    else $error("unchanged pins did not skip the divide");

  a_done_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qed_pkg::ST_DONE) |-> (reported_r == detent_r))
    else $error("reported position not settled at result");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == qed_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_pins_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(last_pins_r)) |-> ($past(state_r) == qed_pkg::ST_STEP))
    else $error("pin state moved outside the step state");

endmodule

[tb/sv/quadrature_encoder_accel_decoder_tb.sv]
// self-checking testbench for the quadrature encoder decoder: directed and random pin samples,
// random idling on both sides, results checked against an in-bench decoder model
// depends on qed_pkg, qed_if and the quadrature_encoder_accel_decoder rtl
module quadrature_encoder_accel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ENC_DET_11   = 3'd0;
  localparam logic [2:0] ENC_DET_00   = 3'd1;
  localparam logic [2:0] ENC_DET_BOTH = 3'd2;
  localparam logic [2:0] ENC_DET_MID  = 3'd3;
  localparam logic [2:0] ENC_DET_ALL  = 3'd4;

  localparam int GRAY_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic        pin_a;
    logic        pin_b;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [2:0]         ev;
    logic signed [15:0] pos;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_wdata;

  qed_in_if  in_ch ();
  qed_out_if out_ch ();

  quadrature_encoder_accel_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder model state and configuration
  logic [2:0]  enc_type;
  logic [14:0] fast_lim;
  logic [14:0] max_pos;
  logic [1:0]  last_pins;
  logic [31:0] fine_pos;
  logic [15:0] detent_pos;
  logic [15:0] shown_pos;
  logic [31:0] last_det_t;
  logic [31:0] prior_det_t;

  sample_t  queued_samples [$];
  reading_t awaited_readings [$];
  int       samples_queued = 0;
  int       samples_taken = 0;
  int       readings_seen = 0;
  int       mismatches = 0;
  bit       idle_on;
  int       send_gap;
  int       stall_left;
  int       hold_left;
  bit       held;
  sample_t  taken;
  sample_t  next_sample;
  reading_t got;
  reading_t want;
  logic [1:0]  stim_pins;
  logic [31:0] stim_time;

  function automatic reading_t decode_sample(sample_t s);
    logic [1:0]         pins;
    logic [1:0]         shift;
    logic [3:0]         mask;
    logic [31:0]        span;
    logic [31:0]        inc;
    logic signed [31:0] shifted;
    logic signed [15:0] d16;
    int                 speed;
    int                 pos;
    int                 rep;
    int                 delta;
    int                 mag;
    int                 probe;
    bit                 up;
    reading_t           r;
    pins = {s.pin_b, s.pin_a};
    case (enc_type)
      ENC_DET_11:   begin mask = 4'h8; shift = 2'd2; end
      ENC_DET_00:   begin mask = 4'h1; shift = 2'd2; end
      ENC_DET_BOTH: begin mask = 4'h9; shift = 2'd1; end
      ENC_DET_MID:  begin mask = 4'h6; shift = 2'd1; end
      default:      begin mask = 4'hF; shift = 2'd0; end
    endcase
    if (pins != last_pins) begin
      span = 32'd1 + last_det_t - prior_det_t;
      speed = 1 + ((span == 32'd0) ? 0 : int'(32'd1000 / span));
      inc = GRAY_STEP[{last_pins, pins}] * speed;
      fine_pos = fine_pos + (inc << shift);
      if (mask[pins]) begin
        prior_det_t = last_det_t;
        last_det_t = s.now_ms;
        shifted = $signed(fine_pos) >>> shift;
        detent_pos = shifted[15:0];
      end
      last_pins = pins;
    end
    pos = int'($signed(detent_pos));
    rep = int'($signed(shown_pos));
    r.ev = qed_pkg::EV_NONE;
    if (pos != rep) begin
      d16 = 16'(pos - rep);
      delta = int'(d16);
      up = delta >= 0;
      mag = up ? delta : -delta;
      if (mag < int'(fast_lim)) r.ev = up ? qed_pkg::EV_SLOW_UP : qed_pkg::EV_SLOW_DN;
      else r.ev = up ? qed_pkg::EV_FAST_UP : qed_pkg::EV_FAST_DN;
      probe = pos + 2 * delta;
      if ((up && probe > int'(max_pos)) || (!up && probe < -int'(max_pos))) begin
        fine_pos = fine_pos & 32'h3;
        detent_pos = 16'd0;
        pos = 0;
      end
      shown_pos = pos[15:0];
    end
    r.pos = shown_pos;
    return r;
  endfunction

  function automatic logic [1:0] gray_next(logic [1:0] p, bit fwd);
    logic [1:0] n;
    case (p)
      2'd0:    n = fwd ? 2'd2 : 2'd1;
      2'd2:    n = fwd ? 2'd3 : 2'd0;
      2'd3:    n = fwd ? 2'd1 : 2'd2;
      default: n = fwd ? 2'd0 : 2'd3;
    endcase
    return n;
  endfunction

  task automatic push_sample(logic [1:0] p, logic [31:0] t);
    queued_samples.push_back('{pin_a: p[0], pin_b: p[1], now_ms: t});
    samples_queued++;
    stim_pins = p;
    stim_time = t;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      qed_pkg::CFG_ENC_TYPE:   enc_type = val[2:0];
      qed_pkg::CFG_FAST_LIMIT: fast_lim = val;
      qed_pkg::CFG_MAX_POS:    max_pos = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (samples_taken != samples_queued || awaited_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [2:0] typ, logic [14:0] fast, logic [14:0] lim);
    wait_idle();
    write_reg(qed_pkg::CFG_ENC_TYPE, 15'(typ));
    write_reg(qed_pkg::CFG_FAST_LIMIT, fast);
    write_reg(qed_pkg::CFG_MAX_POS, lim);
    @(negedge clk);
  endtask

  task automatic run_random(logic [2:0] typ, logic [14:0] fast, logic [14:0] lim,
                            int count, bit idle);
    bit fwd;
    int r;
    logic [1:0]  p;
    logic [31:0] t;
    configure(typ, fast, lim);
    idle_on = idle;
    fwd = 1'($urandom_range(0, 1));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 6) fwd = !fwd;
      p = stim_pins;
      t = stim_time;
      r = $urandom_range(0, 99);
      if (r < 72) p = gray_next(p, fwd);
      else if (r < 90 && r >= 82) p = ~p;
      else if (r >= 90) p = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: t = t + $urandom_range(0, 5);
        4, 5, 6, 7: t = t + $urandom_range(0, 300);
        8:          t = t + $urandom_range(300, 3000);
        default:    t = $urandom;
      endcase
      push_sample(p, t);
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.pin_a = in_ch.pin_a;
        taken.pin_b = in_ch.pin_b;
        taken.now_ms = in_ch.now_ms;
        awaited_readings.push_back(decode_sample(taken));
        samples_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (queued_samples.size() > 0) begin
          next_sample = queued_samples.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.pin_a <= next_sample.pin_a;
          in_ch.pin_b <= next_sample.pin_b;
          in_ch.now_ms <= next_sample.now_ms;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      held = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.ev = out_ch.event_res;
        got.pos = out_ch.position;
        if (awaited_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, event %0d position %0d",
                   $time, got.ev, got.pos);
        end else begin
          want = awaited_readings.pop_front();
          if (got.ev !== want.ev) begin
            mismatches++;
            $display("%0t: event_res expected %0d, got %0d", $time, want.ev, got.ev);
          end
          if (got.pos !== want.pos) begin
            mismatches++;
            $display("%0t: position expected %0d, got %0d", $time, want.pos, got.pos);
          end
        end
        readings_seen++;
        if (!held && readings_seen == HOLD_AT) begin
          held = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pin_a = 1'b0;
    in_ch.pin_b = 1'b0;
    in_ch.now_ms = 32'd0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = qed_pkg::CFG_ENC_TYPE;
    cfg_wdata = 15'd0;
    enc_type = ENC_DET_11;
    fast_lim = 15'd5;
    max_pos = 15'd30000;
    last_pins = 2'd0;
    fine_pos = 32'd0;
    detent_pos = 16'd0;
    shown_pos = 16'd0;
    last_det_t = 32'd0;
    prior_det_t = 32'd0;
    idle_on = 1'b1;
    stim_pins = 2'd0;
    stim_time = 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: forward turn, wrapped detent interval, backward turn, illegal jumps
    push_sample(2'd0, 32'd0);
    push_sample(2'd2, 32'd10);
    push_sample(2'd3, 32'd20);
    push_sample(2'd1, 32'd30);
    push_sample(2'd0, 32'd40);
    push_sample(2'd2, 32'd50);
    push_sample(2'd3, 32'd19);
    push_sample(2'd1, 32'hFFFF_FFFF);
    push_sample(2'd3, 32'd5);
    push_sample(2'd2, 32'd100);
    push_sample(2'd0, 32'd200);
    push_sample(2'd1, 32'd300);
    push_sample(2'd3, 32'd2000);
    push_sample(2'd0, 32'd2001);
    push_sample(2'd3, 32'd2002);
    push_sample(2'd3, 32'd2003);
    push_sample(2'd1, 32'h8000_0000);

    // out-of-range type, zero limits: every move is fast and clears
    configure(3'd7, 15'd0, 15'd0);
    push_sample(2'd0, 32'h8000_0010);
    push_sample(2'd2, 32'h8000_0011);
    push_sample(2'd3, 32'h8000_0012);
    push_sample(2'd2, 32'h8000_0013);
    push_sample(2'd0, 32'h8000_0500);
    push_sample(2'd0, 32'h8000_0501);

    run_random(ENC_DET_11, 15'd5, 15'd30000, 90, 1'b1);
    run_random(ENC_DET_00, 15'd1, 15'd32767, 90, 1'b1);
    run_random(ENC_DET_BOTH, 15'd32767, 15'd1, 90, 1'b1);
    run_random(ENC_DET_MID, 15'd3, 15'd200, 90, 1'b1);
    run_random(ENC_DET_ALL, 15'd10, 15'd1000, 90, 1'($urandom_range(0, 1)));
    run_random(3'd5, 15'd2, 15'd50, 90, 1'b1);
    run_random(3'd6, 15'd0, 15'd0, 90, 1'($urandom_range(0, 1)));
    run_random(ENC_DET_BOTH, 15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
               90, 1'b1);
    run_random(ENC_DET_11, 15'd1, 15'd500, 90, 1'b1);
    run_random(ENC_DET_MID, 15'd20, 15'd5000, 90, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/qed_pkg.sv
hw/rtl/qed_if.sv
hw/rtl/qed_div.sv
hw/rtl/quadrature_encoder_accel_decoder.sv
tb/sv/quadrature_encoder_accel_decoder_tb.sv
